@@ sv/rgbluv_pkg.sv @@
// Shared constants, types and the lightness ROM builder for the RGB to Luv converter.
// Used by every module of the converter; depends on nothing.
package rgbluv_pkg;

   // Configuration of the table and the output format
   localparam int LIGHT_TABLE_ENTRIES = 1025;
   localparam int OUT_FRAC_BITS = 8;

   // Pixel and XYZ widths
   localparam int CH_W = 8;
   localparam int X_W = 24;
   localparam int Y_W = 24;
   localparam int Z_W = 25;
   localparam int D_W = 29;
   localparam int OUT_W = 16;
   localparam logic [OUT_W-1:0] OUT_MAX = '1;

   // Matrix coefficients in Q16 (rows X, Y, Z; columns red, green, blue)
   localparam int MX_R = 28218;
   localparam int MX_G = 22384;
   localparam int MX_B = 11687;
   localparam int MY_R = 14550;
   localparam int MY_G = 46311;
   localparam int MY_B = 4675;
   localparam int MZ_R = 1323;
   localparam int MZ_G = 8490;
   localparam int MZ_B = 61550;

   // Table index: floor(Y * span / (255 * 2^16)) by reciprocal and one correction
   localparam int LIGHT_SPAN = LIGHT_TABLE_ENTRIES - 1;
   localparam int IDX_W = $clog2(LIGHT_TABLE_ENTRIES);
   localparam int Y_DEN = 255 * 65536;
   localparam int IDX_AW = Y_W + IDX_W;
   localparam longint unsigned IDX_K = (64'd1 << IDX_AW) / Y_DEN;
   localparam longint unsigned IDX_SK = IDX_K * LIGHT_SPAN;
   localparam int IDX_PROD_W = Y_W + IDX_AW;

   // Lightness values (Q16, 0..100)
   localparam int L_W = 23;
   localparam int L13_W = 27;

   // Divider: quotients floor(X * 2^18 / D) and floor(9Y * 2^18 / D)
   localparam int Q_W = 18;
   localparam int V_W = Q_W - 2;
   localparam int DIV_STEPS_PER_STAGE = 3;
   localparam int DIV_STAGES = Q_W / DIV_STEPS_PER_STAGE;
   localparam int LIGHT_DELAY = DIV_STAGES - 2;

   // Output scaling
   localparam int WHITE_U = 12965;
   localparam int WHITE_V = 30693;
   localparam int DIFF_W = Q_W + 1;
   localparam int P_W = L13_W + 1 + DIFF_W;
   localparam int N_W = 55;
   localparam longint NU_C = 64'd255 * 64'd134 * (64'd1 << 32);
   localparam longint NV_C = 64'd255 * 64'd140 * (64'd1 << 32);
   localparam int U_SHIFT = 32 - OUT_FRAC_BITS;
   localparam int V_SHIFT = 40 - OUT_FRAC_BITS;
   localparam int AU_W = N_W - 1 - U_SHIFT;
   localparam int AV_W = N_W - 1 - V_SHIFT;
   localparam int U_DEN = 354;
   localparam int U_SAT = U_DEN * 65536;
   localparam int U_AW = $clog2(U_SAT);
   localparam longint unsigned U_K = (64'd1 << U_AW) / U_DEN;
   localparam int LA_W = 31;
   localparam int L_SHIFT = 16 - OUT_FRAC_BITS;
   localparam int L_DEN = 100;
   localparam int L_SAT = L_DEN * 65536;
   localparam int L_AW = $clog2(L_SAT);
   localparam longint unsigned L_K = (64'd1 << L_AW) / L_DEN;

   // Pipeline depth: matrix (2), divider, output scaling (4)
   localparam int PIPE_DEPTH = 2 + DIV_STAGES + 4;

   typedef struct packed {
      logic [D_W-1:0] rem;
      logic [Q_W-1:0] quo;
   } div_lane_type;

   typedef logic [L_W-1:0] light_rom_type [LIGHT_TABLE_ENTRIES];

   // Quotient for the table contents, evaluated once at elaboration
   function automatic longint unsigned rom_quot(longint unsigned a, longint unsigned b);
      longint unsigned q;
      longint unsigned r;
      q = 0;
      r = 0;
      for (int k = 63; k >= 0; k--) begin
         r = {r[62:0], a[k]};
         if (r >= b) begin
            r = r - b;
            q[k] = 1'b1;
         end
      end
      return q;
   endfunction

   // Lightness ROM: 116*cbrt(y)-16 above the knee, linear at or below it
   function automatic light_rom_type build_light_rom();
      light_rom_type rom;
      longint unsigned span;
      longint unsigned idx;
      longint unsigned n;
      longint unsigned lo;
      longint unsigned hi;
      longint unsigned mid;
      span = longint'(LIGHT_SPAN);
      for (int i = 0; i < LIGHT_TABLE_ENTRIES; i++) begin
         idx = longint'(i);
         if (idx * 24389 > 216 * span) begin
            n = rom_quot(idx << 48, span);
            lo = 0;
            hi = 64'd1 << 21;
            for (int k = 0; k < 21; k++) begin
               if (hi - lo > 1) begin
                  mid = (lo + hi) >> 1;
                  if (mid * mid * mid <= n) begin
                     lo = mid;
                  end else begin
                     hi = mid;
                  end
               end
            end
            rom[i] = L_W'(116 * lo - 16 * 65536);
         end else begin
            rom[i] = L_W'(rom_quot(idx * 24389 * 65536, 27 * span));
         end
      end
      return rom;
   endfunction

endpackage

@@ sv/rgbluv_color_matrix.sv @@
// Color matrix stages: BGR bytes to X, Y, Z, then the Luv denominator and the
// first estimate of the lightness table index. Depends on rgbluv_pkg.
module rgbluv_color_matrix (
   input  logic                           clock,
   input  logic                           en,
   input  logic [rgbluv_pkg::CH_W-1:0]    blue,
   input  logic [rgbluv_pkg::CH_W-1:0]    green,
   input  logic [rgbluv_pkg::CH_W-1:0]    red,
   output logic [rgbluv_pkg::D_W-1:0]     den,
   output logic [rgbluv_pkg::D_W-1:0]     num_u,
   output logic [rgbluv_pkg::D_W-1:0]     num_v,
   output logic [rgbluv_pkg::Y_W-1:0]     luma,
   output logic [rgbluv_pkg::IDX_W-1:0]   idx_est
);
   import rgbluv_pkg::*;

   logic [X_W-1:0] x_ff, x_in;
   logic [Y_W-1:0] y_ff, y_in;
   logic [Z_W-1:0] z_ff, z_in;
   logic [D_W-1:0] den_ff, den_in;
   logic [D_W-1:0] num_u_ff, num_u_in;
   logic [D_W-1:0] num_v_ff, num_v_in;
   logic [Y_W-1:0] luma_ff, luma_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [IDX_PROD_W-1:0] idx_prod;

   always_comb begin
      x_in = X_W'(32'(red) * 32'(MX_R) + 32'(green) * 32'(MX_G) + 32'(blue) * 32'(MX_B));
      y_in = Y_W'(32'(red) * 32'(MY_R) + 32'(green) * 32'(MY_G) + 32'(blue) * 32'(MY_B));
      z_in = Z_W'(32'(red) * 32'(MZ_R) + 32'(green) * 32'(MZ_G) + 32'(blue) * 32'(MZ_B));

      den_in = D_W'(x_ff) + D_W'(y_ff) * D_W'(15) + D_W'(z_ff) * D_W'(3);
      num_u_in = D_W'(x_ff);
      num_v_in = D_W'(y_ff) * D_W'(9);
      luma_in = y_ff;
      // estimate is exact or one low
      idx_prod = IDX_PROD_W'(y_ff) * IDX_PROD_W'(IDX_SK);
      idx_in = idx_prod[IDX_AW +: IDX_W];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
         den_ff <= den_in;
         num_u_ff <= num_u_in;
         num_v_ff <= num_v_in;
         luma_ff <= luma_in;
         idx_ff <= idx_in;
      end
   end

   assign den = den_ff;
   assign num_u = num_u_ff;
   assign num_v = num_v_ff;
   assign luma = luma_ff;
   assign idx_est = idx_ff;

endmodule

@@ sv/rgbluv_light_lookup.sv @@
// Lightness path: index correction, ROM read, and a delay line that keeps the
// lightness aligned with the divider. Depends on rgbluv_pkg.
module rgbluv_light_lookup (
   input  logic                           clock,
   input  logic                           en,
   input  logic [rgbluv_pkg::Y_W-1:0]     luma,
   input  logic [rgbluv_pkg::IDX_W-1:0]   idx_est,
   output logic [rgbluv_pkg::L_W-1:0]     light,
   output logic [rgbluv_pkg::L13_W-1:0]   light13
);
   import rgbluv_pkg::*;

   localparam light_rom_type LightRom = build_light_rom();

   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [L_W-1:0] rom_ff;
   logic [L_W-1:0] l_ff [LIGHT_DELAY];
   logic [L13_W-1:0] l13_ff [LIGHT_DELAY];
   logic [IDX_AW-1:0] prod_a, prod_q, rem;
   logic [IDX_W:0] idx_up;

   always_comb begin
      prod_a = IDX_AW'(luma) * IDX_AW'(LIGHT_SPAN);
      prod_q = IDX_AW'(idx_est) * IDX_AW'(Y_DEN);
      rem = prod_a - prod_q;
      idx_up = {1'b0, idx_est} + (IDX_W+1)'(rem >= IDX_AW'(Y_DEN));
      if (idx_up > (IDX_W+1)'(LIGHT_SPAN)) begin
         idx_in = IDX_W'(LIGHT_SPAN);
      end else begin
         idx_in = idx_up[IDX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         idx_ff <= idx_in;
         rom_ff <= LightRom[idx_ff];
         l_ff[0] <= rom_ff;
         l13_ff[0] <= L13_W'(rom_ff) * L13_W'(13);
         for (int i = 1; i < LIGHT_DELAY; i++) begin
            l_ff[i] <= l_ff[i-1];
            l13_ff[i] <= l13_ff[i-1];
         end
      end
   end

   assign light = l_ff[LIGHT_DELAY-1];
   assign light13 = l13_ff[LIGHT_DELAY-1];

endmodule

@@ sv/rgbluv_recip_div.sv @@
// Pipelined restoring divider for u' and v', a few quotient bits per stage,
// both lanes sharing one denominator. Depends on rgbluv_pkg.
module rgbluv_recip_div (
   input  logic                         clock,
   input  logic                         en,
   input  logic [rgbluv_pkg::D_W-1:0]   den,
   input  logic [rgbluv_pkg::D_W-1:0]   num_u,
   input  logic [rgbluv_pkg::D_W-1:0]   num_v,
   output logic [rgbluv_pkg::Q_W-1:0]   u_prime,
   output logic [rgbluv_pkg::V_W-1:0]   v_prime
);
   import rgbluv_pkg::*;

   div_lane_type lane_u_ff [DIV_STAGES];
   div_lane_type lane_v_ff [DIV_STAGES];
   logic [D_W-1:0] den_ff [DIV_STAGES];
   logic zero_den;

   function automatic div_lane_type div_stage(div_lane_type st, logic [D_W-1:0] d);
      div_lane_type nx;
      logic [D_W:0] sh;
      nx = st;
      for (int i = 0; i < DIV_STEPS_PER_STAGE; i++) begin
         sh = {nx.rem, 1'b0};
         if (sh >= {1'b0, d}) begin
            nx.rem = D_W'(sh - {1'b0, d});
            nx.quo = {nx.quo[Q_W-2:0], 1'b1};
         end else begin
            nx.rem = sh[D_W-1:0];
            nx.quo = {nx.quo[Q_W-2:0], 1'b0};
         end
      end
      return nx;
   endfunction

   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
      div_lane_type src_u, src_v;
      logic [D_W-1:0] src_d;
      if (s == 0) begin : g_first
         always_comb begin
            src_u = '{rem: num_u, quo: '0};
            src_v = '{rem: num_v, quo: '0};
            src_d = den;
         end
      end else begin : g_next
         always_comb begin
            src_u = lane_u_ff[s-1];
            src_v = lane_v_ff[s-1];
            src_d = den_ff[s-1];
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            lane_u_ff[s] <= div_stage(src_u, src_d);
            lane_v_ff[s] <= div_stage(src_v, src_d);
            den_ff[s] <= src_d;
         end
      end
   end

   // black pixel: force both ratios to zero
   assign zero_den = (den_ff[DIV_STAGES-1] == '0);
   assign u_prime = zero_den ? '0 : lane_u_ff[DIV_STAGES-1].quo;
   assign v_prime = zero_den ? '0 : lane_v_ff[DIV_STAGES-1].quo[Q_W-1:2];

endmodule

@@ sv/rgbluv_out_scale.sv @@
// Output scaling: chroma products, offset and 255 scaling, constant division
// by reciprocal with one correction, and saturation. Depends on rgbluv_pkg.
module rgbluv_out_scale (
   input  logic                           clock,
   input  logic                           en,
   input  logic [rgbluv_pkg::L_W-1:0]     light,
   input  logic [rgbluv_pkg::L13_W-1:0]   light13,
   input  logic [rgbluv_pkg::Q_W-1:0]     u_prime,
   input  logic [rgbluv_pkg::V_W-1:0]     v_prime,
   output logic [rgbluv_pkg::OUT_W-1:0]   lightness,
   output logic [rgbluv_pkg::OUT_W-1:0]   chroma_u,
   output logic [rgbluv_pkg::OUT_W-1:0]   chroma_v
);
   import rgbluv_pkg::*;

   // stage 1
   logic signed [P_W-1:0] pu_ff, pu_in, pv_ff, pv_in;
   logic [LA_W-1:0] la_ff, la_in;
   logic signed [DIFF_W-1:0] du, dv;
   // stage 2
   logic signed [N_W-1:0] nu, nv;
   logic [AU_W-1:0] au_ff, au_in;
   logic [AV_W-1:0] av_ff, av_in;
   logic neg_u_ff, neg_v_ff, neg_u2_ff, neg_v2_ff;
   logic [LA_W-1:0] al;
   logic [L_AW-1:0] al_ff, al_in;
   logic sat_l_ff, sat_l_in, sat_l2_ff;
   // stage 3
   logic [2*U_AW-1:0] u_prod;
   logic [2*L_AW-1:0] l_prod;
   logic [U_AW-1:0] au_lo_ff;
   logic [L_AW-1:0] al_lo_ff;
   logic [OUT_W-1:0] qu0_ff, qu0_in, ql0_ff, ql0_in, av_lo_ff;
   logic sat_u_ff, sat_u_in, sat_v_ff, sat_v_in;
   // stage 4
   logic [U_AW-1:0] ru;
   logic [L_AW-1:0] rl;
   logic [OUT_W-1:0] qu, ql;
   logic [OUT_W-1:0] lightness_ff, lightness_in;
   logic [OUT_W-1:0] chroma_u_ff, chroma_u_in, chroma_v_ff, chroma_v_in;

   always_comb begin
      du = $signed(DIFF_W'(u_prime) - DIFF_W'(WHITE_U));
      dv = $signed(DIFF_W'(v_prime) - DIFF_W'(WHITE_V));
      pu_in = $signed({1'b0, light13}) * du;
      pv_in = $signed({1'b0, light13}) * dv;
      la_in = LA_W'(light) * LA_W'(255);

      nu = (N_W'(pu_ff) <<< 8) - N_W'(pu_ff) + N_W'(NU_C);
      nv = (N_W'(pv_ff) <<< 8) - N_W'(pv_ff) + N_W'(NV_C);
      au_in = AU_W'(nu[N_W-2:0] >> U_SHIFT);
      av_in = AV_W'(nv[N_W-2:0] >> V_SHIFT);
      al = la_ff >> L_SHIFT;
      sat_l_in = (al >= LA_W'(L_SAT));
      al_in = al[L_AW-1:0];

      u_prod = (2*U_AW)'(au_ff[U_AW-1:0]) * (2*U_AW)'(U_K);
      l_prod = (2*L_AW)'(al_ff) * (2*L_AW)'(L_K);
      qu0_in = OUT_W'(u_prod >> U_AW);
      ql0_in = OUT_W'(l_prod >> L_AW);
      sat_u_in = (au_ff >= AU_W'(U_SAT));
      sat_v_in = |av_ff[AV_W-1:OUT_W];

      // estimate is exact or one low: fix with a single compare
      ru = au_lo_ff - U_AW'(qu0_ff) * U_AW'(U_DEN);
      rl = al_lo_ff - L_AW'(ql0_ff) * L_AW'(L_DEN);
      qu = qu0_ff + OUT_W'(ru >= U_AW'(U_DEN));
      ql = ql0_ff + OUT_W'(rl >= L_AW'(L_DEN));

      if (neg_u2_ff) begin
         chroma_u_in = '0;
      end else if (sat_u_ff) begin
         chroma_u_in = OUT_MAX;
      end else begin
         chroma_u_in = qu;
      end
      if (neg_v2_ff) begin
         chroma_v_in = '0;
      end else if (sat_v_ff) begin
         chroma_v_in = OUT_MAX;
      end else begin
         chroma_v_in = av_lo_ff;
      end
      lightness_in = sat_l2_ff ? OUT_MAX : ql;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pu_ff <= pu_in;
         pv_ff <= pv_in;
         la_ff <= la_in;

         au_ff <= au_in;
         av_ff <= av_in;
         neg_u_ff <= nu[N_W-1];
         neg_v_ff <= nv[N_W-1];
         al_ff <= al_in;
         sat_l_ff <= sat_l_in;

         qu0_ff <= qu0_in;
         ql0_ff <= ql0_in;
         au_lo_ff <= au_ff[U_AW-1:0];
         al_lo_ff <= al_ff;
         av_lo_ff <= av_ff[OUT_W-1:0];
         sat_u_ff <= sat_u_in;
         sat_v_ff <= sat_v_in;
         sat_l2_ff <= sat_l_ff;
         neg_u2_ff <= neg_u_ff;
         neg_v2_ff <= neg_v_ff;

         lightness_ff <= lightness_in;
         chroma_u_ff <= chroma_u_in;
         chroma_v_ff <= chroma_v_in;
      end
   end

   assign lightness = lightness_ff;
   assign chroma_u = chroma_u_ff;
   assign chroma_v = chroma_v_ff;

endmodule

@@ sv/rgb_to_luv_pixel_converter.sv @@
// Top level of the BGR to CIE Luv pixel converter: valid chain, stall control
// and the four pipeline parts. Depends on rgbluv_pkg and the rgbluv_* modules.
//
//   channel | direction | handshake              | payload
//   req     | in        | req_valid / req_ready  | req_blue, req_green, req_red (8 b each)
//   rsp     | out       | rsp_valid / rsp_ready  | rsp_lightness, rsp_chroma_u, rsp_chroma_v
//
// One pixel per clock unless the pipe holds; each transaction passes through the
// matrix, the divider (three quotient bits a stage) and output scaling in turn.
// Synchronous reset clears the valid bits only.
// The whole pipe holds while a finished result waits and rsp_ready is low.
module rgb_to_luv_pixel_converter (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [rgbluv_pkg::CH_W-1:0]    req_blue,
   input  logic [rgbluv_pkg::CH_W-1:0]    req_green,
   input  logic [rgbluv_pkg::CH_W-1:0]    req_red,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [rgbluv_pkg::OUT_W-1:0]   rsp_lightness,
   output logic [rgbluv_pkg::OUT_W-1:0]   rsp_chroma_u,
   output logic [rgbluv_pkg::OUT_W-1:0]   rsp_chroma_v
);
   import rgbluv_pkg::*;

   logic [PIPE_DEPTH-1:0] vld_ff, vld_in;
   logic en;
   logic [D_W-1:0] den, num_u, num_v;
   logic [Y_W-1:0] luma;
   logic [IDX_W-1:0] idx_est;
   logic [L_W-1:0] light;
   logic [L13_W-1:0] light13;
   logic [Q_W-1:0] u_prime;
   logic [V_W-1:0] v_prime;

   // advance unless the output holds a result that is not taken
   assign en = ~vld_ff[PIPE_DEPTH-1] | rsp_ready;
   assign vld_in = {vld_ff[PIPE_DEPTH-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   rgbluv_color_matrix u_matrix (
      .clock   (clock),
      .en      (en),
      .blue    (req_blue),
      .green   (req_green),
      .red     (req_red),
      .den     (den),
      .num_u   (num_u),
      .num_v   (num_v),
      .luma    (luma),
      .idx_est (idx_est)
   );

   rgbluv_light_lookup u_light (
      .clock   (clock),
      .en      (en),
      .luma    (luma),
      .idx_est (idx_est),
      .light   (light),
      .light13 (light13)
   );

   rgbluv_recip_div u_div (
      .clock   (clock),
      .en      (en),
      .den     (den),
      .num_u   (num_u),
      .num_v   (num_v),
      .u_prime (u_prime),
      .v_prime (v_prime)
   );

   rgbluv_out_scale u_out (
      .clock     (clock),
      .en        (en),
      .light     (light),
      .light13   (light13),
      .u_prime   (u_prime),
      .v_prime   (v_prime),
      .lightness (rsp_lightness),
      .chroma_u  (rsp_chroma_u),
      .chroma_v  (rsp_chroma_v)
   );

   assign req_ready = en;
   assign rsp_valid = vld_ff[PIPE_DEPTH-1];

endmodule
